// ===== design/ghc_pkg.sv =====
package ghc_pkg;

  // Fixed-point formats
  localparam int TEMP_FRAC_BITS = 4;
  localparam int CP_FRAC_BITS   = 16;

  localparam int MODE_W = 4;
  localparam int TEMP_W = 20;
  localparam int HC_W   = 25;

  // Clamped temperature, 1/16 K units, at most 6000 K
  localparam int T1_W   = 17;
  // t = T/1000 and u = 1000/T in Q32
  localparam int T_W    = 35;
  localparam int U_W    = 36;
  localparam int DEND_W = 47;
  // Multiplier operands and rounded Q32 products
  localparam int OP_W   = 40;
  localparam int RES_W  = 48;
  localparam int COEF_W = 40;
  localparam int ROW_W  = 5;
  localparam int ROWS   = 20;
  localparam int SUM_W  = 56;
  localparam int V_W    = 27;

  localparam int T_UNIT = 1000 << TEMP_FRAC_BITS;
  localparam int T_HI_K = 6000;

  // t = T1*T_QI + floor((T1*T_QR + T_UNIT/2) / T_UNIT)
  localparam logic [31:0] T_QI   = 32'((64'd1 << 32) / 64'(T_UNIT));
  localparam logic [31:0] T_QR   = 32'((64'd1 << 32) % 64'(T_UNIT));
  localparam logic [31:0] T_HALF = 32'(T_UNIT / 2);
  localparam int          Z_W    = 31;
  localparam int          T_RS   = 44;
  localparam logic [31:0] T_RM   = 32'(((64'd1 << T_RS) + 64'(T_UNIT) - 64'd1) / 64'(T_UNIT));

  // Dividend of the reciprocal, before the rounding half of T is added
  localparam logic [DEND_W-1:0] DEND_N = DEND_W'(T_UNIT) << 32;

  // Final scaling
  localparam int          SH      = 32 - CP_FRAC_BITS;
  localparam int          DIV5_S  = 30;
  localparam logic [31:0] DIV5_M  = 32'(((64'd1 << DIV5_S) + 64'd4) / 64'd5);
  localparam logic [V_W-1:0] V_MAX = {V_W{1'b1}};
  localparam logic [V_W-1:0] Q_POS_MAX = V_W'((64'd1 << (HC_W - 1)) - 64'd1);
  localparam logic [V_W-1:0] Q_NEG_MAX = V_W'(64'd1 << (HC_W - 1));

  typedef enum logic [MODE_W-1:0] {
    GAS_AIR = 4'd0,
    GAS_CO2 = 4'd1,
    GAS_HE  = 4'd2,
    GAS_N2  = 4'd3,
    GAS_NH3 = 4'd4,
    GAS_CH4 = 4'd5,
    GAS_H2  = 4'd6,
    GAS_O2  = 4'd7,
    GAS_CO  = 4'd8,
    GAS_H2O = 4'd9
  } gas_code_t;

  typedef struct packed {
    logic             air;
    logic             zero;
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row1;
  } meta_t;

  typedef struct packed {
    meta_t           meta;
    logic [T1_W-1:0] temp;
  } item_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [0:4] coef_set_t;

  // Coefficient from millionths to Q32, rounded to nearest
  function automatic coef_t cq(longint m);
    longint r;
    if (m >= 0) begin
      r = (m * 64'sd67108864 + 64'sd7812) / 64'sd15625;
    end else begin
      r = (m * 64'sd67108864 - 64'sd7812) / 64'sd15625;
    end
    return coef_t'(r);
  endfunction

  // One row per gas and temperature band: A, B, C, D, E
  localparam coef_set_t COEF [ROWS] = '{
    '{cq(24997350), cq(55186960), cq(-33691370), cq(7948387), cq(-136638)},
    '{cq(58166390), cq(2720074), cq(-492289), cq(38844), cq(-6447293)},
    '{cq(20786030), 40'sd2, -40'sd1, 40'sd0, 40'sd0},
    '{cq(28986410), cq(1853978), cq(-9647459), cq(16635370), cq(117)},
    '{cq(19505830), cq(19887050), cq(-8598535), cq(1369784), cq(527601)},
    '{cq(35518720), cq(1128728), cq(-196103), cq(14662), cq(-4553760)},
    '{cq(19995630), cq(49771190), cq(-15375990), cq(1921168), cq(189174)},
    '{cq(52024270), cq(18488010), cq(-3765128), cq(248541), cq(-12457990)},
    '{cq(-703029), cq(108477300), cq(-42521570), cq(5862788), cq(678565)},
    '{cq(85812170), cq(11264670), cq(-2114146), cq(138190), cq(-26422210)},
    '{cq(33066178), cq(-11363417), cq(11432816), cq(-2772874), cq(-158558)},
    '{cq(18563083), cq(12257357), cq(-2859786), cq(268238), cq(1977990)},
    '{cq(43413560), cq(-4293079), cq(1272428), cq(-96876), cq(-20533862)},
    '{cq(31322340), cq(-20235310), cq(57866440), cq(-36506240), cq(-7374)},
    '{cq(30032350), cq(8772972), cq(-3988133), cq(788313), cq(-741599)},
    '{cq(20911110), cq(10720710), cq(-2020498), cq(146449), cq(9245722)},
    '{cq(25567590), cq(6096130), cq(4054656), cq(-2671301), cq(131021)},
    '{cq(35150700), cq(1300095), cq(-205921), cq(13550), cq(-3282780)},
    '{cq(30092000), cq(6832514), cq(6793435), cq(-2534480), cq(82139)},
    '{cq(41964260), cq(8622053), cq(-1499780), cq(98119), cq(-11157640)}
  };

  function automatic coef_set_t coef_of(logic [ROW_W-1:0] row);
    coef_set_t r;
    r = '0;
    if (row < ROW_W'(ROWS)) begin
      r = COEF[row];
    end
    return r;
  endfunction

endpackage

// ===== design/ghc_if.sv =====
interface ghc_in_if;
  logic                            valid;
  logic                            ready;
  logic [ghc_pkg::MODE_W-1:0]      mode;
  logic [ghc_pkg::TEMP_W-1:0]      temperature;

  modport source (output valid, mode, temperature, input ready);
  modport sink   (input valid, mode, temperature, output ready);
endinterface

interface ghc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ghc_pkg::HC_W-1:0] heat_capacity;

  modport source (output valid, heat_capacity, input ready);
  modport sink   (input valid, heat_capacity, output ready);
endinterface

// ===== design/ghc_front.sv =====
module ghc_front (
  ghc_in_if.sink           sample,
  input  logic             full,
  output logic             push,
  output ghc_pkg::item_t   item
);

  typedef struct packed {
    logic [ghc_pkg::T1_W-1:0]  lo;
    logic [ghc_pkg::T1_W-1:0]  thr0;
    logic [ghc_pkg::T1_W-1:0]  thr1;
    logic [ghc_pkg::ROW_W-1:0] base;
  } gas_info_t;

  localparam logic [ghc_pkg::T1_W-1:0] NEVER = {ghc_pkg::T1_W{1'b1}};

  function automatic logic [ghc_pkg::T1_W-1:0] kel(int k);
    return ghc_pkg::T1_W'(k << ghc_pkg::TEMP_FRAC_BITS);
  endfunction

  function automatic gas_info_t info(logic [ghc_pkg::MODE_W-1:0] g);
    gas_info_t r;
    r = '{lo: kel(298), thr0: NEVER, thr1: NEVER, base: '0};
    case (g)
      ghc_pkg::GAS_CO2: r = '{lo: kel(298), thr0: kel(1200), thr1: NEVER, base: 5'd0};
      ghc_pkg::GAS_HE:  r = '{lo: kel(298), thr0: NEVER, thr1: NEVER, base: 5'd2};
      ghc_pkg::GAS_N2:  r = '{lo: kel(100), thr0: kel(500), thr1: kel(2000), base: 5'd3};
      ghc_pkg::GAS_NH3: r = '{lo: kel(298), thr0: kel(1400), thr1: NEVER, base: 5'd6};
      ghc_pkg::GAS_CH4: r = '{lo: kel(298), thr0: kel(1300), thr1: NEVER, base: 5'd8};
      ghc_pkg::GAS_H2:  r = '{lo: kel(298), thr0: kel(1000), thr1: kel(2500), base: 5'd10};
      ghc_pkg::GAS_O2:  r = '{lo: kel(100), thr0: kel(700), thr1: kel(2000), base: 5'd13};
      ghc_pkg::GAS_CO:  r = '{lo: kel(298), thr0: kel(1300), thr1: NEVER, base: 5'd16};
      ghc_pkg::GAS_H2O: r = '{lo: kel(500), thr0: kel(1700), thr1: NEVER, base: 5'd18};
      default:          r = '{lo: kel(100), thr0: kel(500), thr1: kel(2000), base: 5'd3};
    endcase
    return r;
  endfunction

  function automatic logic [ghc_pkg::ROW_W-1:0] row_of(gas_info_t gi,
                                                       logic [ghc_pkg::T1_W-1:0] t);
    return gi.base + ghc_pkg::ROW_W'(t >= gi.thr0) + ghc_pkg::ROW_W'(t >= gi.thr1);
  endfunction

  logic                             valid_gas;
  logic [ghc_pkg::MODE_W-1:0]       g0;
  gas_info_t                        i0;
  logic [ghc_pkg::TEMP_W-1:0]       lo_ext;
  logic [ghc_pkg::TEMP_W-1:0]       hi_ext;
  logic [ghc_pkg::T1_W-1:0]         t1;

  assign sample.ready = !full;
  assign push         = sample.valid && !full;

  // Air and unused codes clamp with the nitrogen bounds
  assign valid_gas = (sample.mode != ghc_pkg::GAS_AIR) && (sample.mode <= ghc_pkg::GAS_H2O);
  assign g0        = valid_gas ? sample.mode : ghc_pkg::GAS_N2;
  assign i0        = info(g0);
  assign lo_ext    = ghc_pkg::TEMP_W'(i0.lo);
  assign hi_ext    = ghc_pkg::TEMP_W'(kel(ghc_pkg::T_HI_K));

  always_comb begin
    if (sample.temperature < lo_ext) begin
      t1 = i0.lo;
    end else if (sample.temperature > hi_ext) begin
      t1 = kel(ghc_pkg::T_HI_K);
    end else begin
      t1 = sample.temperature[ghc_pkg::T1_W-1:0];
    end
  end

  always_comb begin
    item.temp      = t1;
    item.meta.air  = (sample.mode == ghc_pkg::GAS_AIR);
    item.meta.zero = (sample.mode > ghc_pkg::GAS_H2O);
    item.meta.row0 = row_of(i0, t1);
    item.meta.row1 = row_of(info(ghc_pkg::GAS_O2), t1);
  end

endmodule

// ===== design/ghc_queue.sv =====
module ghc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ghc_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output ghc_pkg::item_t dout,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ghc_pkg::item_t   entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

// ===== design/ghc_recip.sv =====
module ghc_recip #(
  parameter int PAY_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     vin,
  input  logic [ghc_pkg::T1_W-1:0] dvsr,
  input  logic [PAY_W-1:0]         pay_in,
  output logic                     vout,
  output logic [ghc_pkg::U_W-1:0]  quo,
  output logic [PAY_W-1:0]         pay_out
);

  localparam int NW = ghc_pkg::T1_W;
  localparam int QW = ghc_pkg::U_W;

  typedef struct packed {
    logic [NW-1:0]    rem;
    logic [QW-1:0]    dend;
    logic [QW-1:0]    quo;
    logic [NW-1:0]    dvsr;
    logic [PAY_W-1:0] pay;
  } st_t;

  // One restoring step: one quotient bit
  function automatic st_t step(st_t x);
    logic [NW:0] rs;
    logic        ge;
    st_t         y;
    rs     = {x.rem, x.dend[QW-1]};
    ge     = rs >= {1'b0, x.dvsr};
    y      = x;
    y.rem  = ge ? NW'(rs - {1'b0, x.dvsr}) : rs[NW-1:0];
    y.dend = {x.dend[QW-2:0], 1'b0};
    y.quo  = {x.quo[QW-2:0], ge};
    return y;
  endfunction

  logic [ghc_pkg::DEND_W-1:0] dend_full;
  st_t                        x0;
  st_t                        pipe [QW];
  logic [QW-1:0]              vld;

  // Round half up: add T/2 before dividing
  assign dend_full = ghc_pkg::DEND_N + ghc_pkg::DEND_W'(dvsr >> 1);

  always_comb begin
    x0.rem  = NW'(dend_full[ghc_pkg::DEND_W-1:QW]);
    x0.dend = dend_full[QW-1:0];
    x0.quo  = '0;
    x0.dvsr = dvsr;
    x0.pay  = pay_in;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          pipe[k] <= step(x0);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          pipe[k] <= step(pipe[k-1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], vin};
    end
  end

  assign vout    = vld[QW-1];
  assign quo     = pipe[QW-1].quo;
  assign pay_out = pipe[QW-1].pay;

endmodule

// ===== design/ghc_mulq.sv =====
module ghc_mulq (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ghc_pkg::OP_W-1:0]  a,
  input  logic [ghc_pkg::OP_W-1:0]  b,
  output logic [ghc_pkg::RES_W-1:0] r
);

  localparam int HI_W = ghc_pkg::OP_W - 32;

  logic [2*HI_W-1:0] hh;
  logic [HI_W+31:0]  hl;
  logic [HI_W+31:0]  lh;
  logic [63:0]       ll;

  // Partial products, then a rounded sum at 2^-32
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= a[ghc_pkg::OP_W-1:32] * b[ghc_pkg::OP_W-1:32];
      hl <= (HI_W + 32)'(a[ghc_pkg::OP_W-1:32]) * (HI_W + 32)'(b[31:0]);
      lh <= (HI_W + 32)'(a[31:0]) * (HI_W + 32)'(b[ghc_pkg::OP_W-1:32]);
      ll <= 64'(a[31:0]) * 64'(b[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= ghc_pkg::RES_W'({hh, 32'd0}) + ghc_pkg::RES_W'(hl) + ghc_pkg::RES_W'(lh)
         + ghc_pkg::RES_W'((ll + 64'h8000_0000) >> 32);
    end
  end

endmodule

// ===== design/ghc_back.sv =====
module ghc_back (
  input  logic           clk,
  input  logic           rst,
  input  ghc_pkg::item_t q_item,
  input  logic           q_empty,
  output logic           pop,
  ghc_out_if.source      result
);

  localparam int RW = ghc_pkg::RES_W;
  localparam int OW = ghc_pkg::OP_W;
  localparam int SW = ghc_pkg::SUM_W;
  localparam int VW = ghc_pkg::V_W;
  localparam int PAY_W = $bits(ghc_pkg::meta_t) + ghc_pkg::T_W;

  function automatic logic [OW-1:0] mag(ghc_pkg::coef_t c);
    return c[ghc_pkg::COEF_W-1] ? OW'(-c) : OW'(c);
  endfunction

  function automatic logic signed [SW-1:0] term(ghc_pkg::coef_t c, logic [RW-1:0] p);
    logic signed [SW-1:0] e;
    e = $signed(SW'(p));
    return c[ghc_pkg::COEF_W-1] ? -e : e;
  endfunction

  logic en;
  logic out_v;
  logic signed [ghc_pkg::HC_W-1:0] out_hc;

  assign en  = !out_v || result.ready;
  assign pop = en && !q_empty;
  assign result.valid         = out_v;
  assign result.heat_capacity = out_hc;

  // t = T/1000 in two steps
  logic                       v1, v2;
  ghc_pkg::meta_t             m1, m2;
  logic [ghc_pkg::T1_W-1:0]   tk1, tk2;
  logic [ghc_pkg::T_W-1:0]    p1, tv2;
  logic [ghc_pkg::Z_W-1:0]    z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= !q_empty;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= q_item.meta;
      tk1 <= q_item.temp;
      p1  <= ghc_pkg::T_W'(48'(q_item.temp) * 48'(ghc_pkg::T_QI));
      z1  <= ghc_pkg::Z_W'(48'(q_item.temp) * 48'(ghc_pkg::T_QR) + 48'(ghc_pkg::T_HALF));
      m2  <= m1;
      tk2 <= tk1;
      tv2 <= p1 + ghc_pkg::T_W'((64'(z1) * 64'(ghc_pkg::T_RM)) >> ghc_pkg::T_RS);
    end
  end

  // u = 1000/T
  logic                      vr;
  ghc_pkg::meta_t            mr;
  logic [ghc_pkg::T_W-1:0]   tr;
  logic [ghc_pkg::U_W-1:0]   ur;

  ghc_recip #(.PAY_W(PAY_W)) u_recip (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (v2),
    .dvsr    (tk2),
    .pay_in  ({m2, tv2}),
    .vout    (vr),
    .quo     (ur),
    .pay_out ({mr, tr})
  );

  // t^2 and u^2
  logic [RW-1:0]           tt_r, ww_r;
  logic [1:0]              va, vb, vc;
  ghc_pkg::meta_t          ma [2];
  ghc_pkg::meta_t          mb [2];
  ghc_pkg::meta_t          mc [2];
  logic [ghc_pkg::T_W-1:0] ta [2];

  ghc_mulq u_tt (.clk(clk), .en(en), .a(OW'(tr)), .b(OW'(tr)), .r(tt_r));
  ghc_mulq u_ww (.clk(clk), .en(en), .a(OW'(ur)), .b(OW'(ur)), .r(ww_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
      vb <= '0;
      vc <= '0;
    end else if (en) begin
      va <= {va[0], vr};
      vb <= {vb[0], va[1]};
      vc <= {vc[0], vb[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma[0] <= mr;
      ma[1] <= ma[0];
      ta[0] <= tr;
      ta[1] <= ta[0];
      mb[0] <= ma[1];
      mb[1] <= mb[0];
      mc[0] <= mb[1];
      mc[1] <= mc[0];
    end
  end

  // t^3 and the B, C, D, E terms of both lanes
  ghc_pkg::coef_set_t cb [2];
  ghc_pkg::coef_set_t cd [2];
  ghc_pkg::coef_set_t cs [2];
  logic [RW-1:0]      t3_r;
  logic [RW-1:0]      pb [2];
  logic [RW-1:0]      pc [2];
  logic [RW-1:0]      pe [2];
  logic [RW-1:0]      pd [2];
  logic [RW-1:0]      pb_d [2][2];
  logic [RW-1:0]      pc_d [2][2];
  logic [RW-1:0]      pe_d [2][2];

  ghc_mulq u_t3 (.clk(clk), .en(en), .a(OW'(tt_r)), .b(OW'(ta[1])), .r(t3_r));

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign cb[l] = ghc_pkg::coef_of((l == 0) ? ma[1].row0 : ma[1].row1);
    assign cd[l] = ghc_pkg::coef_of((l == 0) ? mb[1].row0 : mb[1].row1);
    assign cs[l] = ghc_pkg::coef_of((l == 0) ? mc[1].row0 : mc[1].row1);

    ghc_mulq u_b (.clk(clk), .en(en), .a(mag(cb[l][1])), .b(OW'(ta[1])), .r(pb[l]));
    ghc_mulq u_c (.clk(clk), .en(en), .a(mag(cb[l][2])), .b(OW'(tt_r)), .r(pc[l]));
    ghc_mulq u_e (.clk(clk), .en(en), .a(mag(cb[l][4])), .b(OW'(ww_r)), .r(pe[l]));
    ghc_mulq u_d (.clk(clk), .en(en), .a(mag(cd[l][3])), .b(OW'(t3_r)), .r(pd[l]));

    // hold B, C, E products while D catches up
    always_ff @(posedge clk) begin
      if (en) begin
        pb_d[l][0] <= pb[l];
        pb_d[l][1] <= pb_d[l][0];
        pc_d[l][0] <= pc[l];
        pc_d[l][1] <= pc_d[l][0];
        pe_d[l][0] <= pe[l];
        pe_d[l][1] <= pe_d[l][0];
      end
    end
  end

  // Sum per lane, then scale and round
  logic                        v_s1, v_s2, v_s3;
  ghc_pkg::meta_t              m_s1;
  logic signed [SW-1:0]        s [2];
  logic signed [SW-1:0]        num;
  logic [SW-1:0]               amag;
  logic [SW-1:0]               rnd;
  logic [SW-1:0]               shv;
  logic                        neg2, air2, zero2, neg3, zero3;
  logic [VW-1:0]               vq2, q3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1  <= 1'b0;
      v_s2  <= 1'b0;
      v_s3  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v_s1  <= vc[1];
      v_s2  <= v_s1;
      v_s3  <= v_s2;
      out_v <= v_s3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_s1 <= mc[1];
      for (int l = 0; l < 2; l++) begin
        s[l] <= SW'(cs[l][0]) + term(cs[l][1], pb_d[l][1]) + term(cs[l][2], pc_d[l][1])
              + term(cs[l][3], pd[l]) + term(cs[l][4], pe_d[l][1]);
      end
    end
  end

  // Air is (4*N2 + O2) / 5
  assign num  = m_s1.air ? (s[0] <<< 2) + s[1] : s[0];
  assign amag = num[SW-1] ? SW'(-num) : SW'(num);
  assign rnd  = amag + (m_s1.air ? (SW'(5) << (ghc_pkg::SH - 1)) : (SW'(1) << (ghc_pkg::SH - 1)));
  assign shv  = rnd >> ghc_pkg::SH;

  always_ff @(posedge clk) begin
    if (en) begin
      neg2  <= num[SW-1];
      air2  <= m_s1.air;
      zero2 <= m_s1.zero;
      vq2   <= (shv > SW'(ghc_pkg::V_MAX)) ? ghc_pkg::V_MAX : VW'(shv);
      neg3  <= neg2;
      zero3 <= zero2;
      q3    <= air2 ? VW'((64'(vq2) * 64'(ghc_pkg::DIV5_M)) >> ghc_pkg::DIV5_S) : vq2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero3) begin
        out_hc <= '0;
      end else if (neg3) begin
        out_hc <= (q3 > ghc_pkg::Q_NEG_MAX) ? ghc_pkg::HC_W'(-ghc_pkg::Q_NEG_MAX)
                                            : ghc_pkg::HC_W'(-q3);
      end else begin
        out_hc <= (q3 > ghc_pkg::Q_POS_MAX) ? ghc_pkg::HC_W'(ghc_pkg::Q_POS_MAX)
                                            : ghc_pkg::HC_W'(q3);
      end
    end
  end

endmodule

// ===== design/gas_heat_capacity_shomate.sv =====
// Channel   Dir  Beat contents
// sample    in   mode[3:0], temperature[19:0] (1/16 K)
// result    out  heat_capacity[24:0] signed (2^-16 J/(mol K))
//
// One beat per cycle in and out when neither side stalls.
// From the queue pop to result valid, the back pipeline computes T/1000
// (its first register stage also pops the queue), the one-bit-per-stage
// reciprocal 1000/T, three rounds of Q32 products, then summing, scaling
// and saturation.
// Reset (rst, synchronous) empties the queue and the pipeline valid bits.
// A stall on result freezes the whole back pipeline; sample keeps taking
// beats until the queue fills.
module gas_heat_capacity_shomate #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  ghc_in_if.sink    sample,
  ghc_out_if.source result
);

  ghc_pkg::item_t f_item;
  ghc_pkg::item_t q_item;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  ghc_front u_front (
    .sample (sample),
    .full   (q_full),
    .push   (push),
    .item   (f_item)
  );

  ghc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_item),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  ghc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_empty (q_empty),
    .pop     (pop),
    .result  (result)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("queue pushed while full");

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
